FILE: rtl/core/sdc_pkg.sv
// Shared types, constants and codes for the signal delivery controller.
`default_nettype none

package sdc_pkg;

  // Signal numbering and the signals with fixed meaning.
  localparam int unsigned NumSignals  = 32;
  localparam int unsigned KillSignal  = 9;
  localparam int unsigned StopSignal  = 17;
  localparam int unsigned ContSignal  = 19;
  localparam int unsigned TableDepth  = 32;

  // Field widths.
  localparam int unsigned OpW    = 3;
  localparam int unsigned SigInW = 6;
  localparam int unsigned SigW   = $clog2(TableDepth);
  localparam int unsigned MaskW  = 32;
  localparam int unsigned HandW  = 64;
  localparam int unsigned EntryW = HandW + MaskW;

  // Handler codes.
  localparam logic [HandW-1:0] HandlerDefault = '0;
  localparam logic [HandW-1:0] HandlerIgnore  = HandW'(1);

  // Signals that can be neither caught nor blocked.
  localparam logic [MaskW-1:0] GuardMask =
      (MaskW'(1) << KillSignal) | (MaskW'(1) << StopSignal);

  typedef enum logic [OpW-1:0] {
    OP_SEND       = 3'd0,
    OP_SET_MASK   = 3'd1,
    OP_SET_ACTION = 3'd2,
    OP_DELIVER    = 3'd3,
    OP_RETURN     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ACT,
    ST_SCAN
  } state_e;

  // Table read address selection.
  typedef enum logic [1:0] {
    RD_SIG,
    RD_ZERO,
    RD_NEXT,
    RD_HOLD
  } rd_sel_e;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [SigInW-1:0] signal_number;
    logic [MaskW-1:0]  mask_in;
    logic [HandW-1:0]  handler_address;
  } item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    exec;
    logic    act;
    logic    scan_init;
    logic    scan_step;
    rd_sel_e rd_sel;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic act_read;
    logic deliver_scan;
    logic slot_free;
    logic scan_end;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/sdc_if.sv
// Request and response channel interfaces of the signal delivery controller.
`default_nettype none

interface sdc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [5:0]  signal_number;
  logic [31:0] mask_in;
  logic [63:0] handler_address;

  modport source (output valid, output operation, output signal_number,
                  output mask_in, output handler_address, input ready);
  modport sink (input valid, input operation, input signal_number,
                input mask_in, input handler_address, output ready);
endinterface

interface sdc_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] mask_out;
  logic [63:0] handler_out;
  logic [4:0]  signal_out;
  logic        handler_started;
  logic        killed_flag;
  logic        stopped_flag;

  modport source (output valid, output status, output mask_out, output handler_out,
                  output signal_out, output handler_started, output killed_flag,
                  output stopped_flag, input ready);
  modport sink (input valid, input status, input mask_out, input handler_out,
                input signal_out, input handler_started, input killed_flag,
                input stopped_flag, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sdc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sdc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/sdc_ctrl.sv
// Controller state machine of the signal delivery controller.
`default_nettype none

module sdc_ctrl
  import sdc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{load: 1'b0, exec: 1'b0, act: 1'b0, scan_init: 1'b0,
                   scan_step: 1'b0, rd_sel: RD_SIG};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.act_read) begin
          // Fetch the old table entry first.
          cmd_o.rd_sel = RD_SIG;
          state_d      = ST_ACT;
        end else if (status_i.deliver_scan) begin
          cmd_o.rd_sel    = RD_ZERO;
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end else if (status_i.slot_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_ACT: begin
        cmd_o.rd_sel = RD_SIG;
        if (status_i.slot_free) begin
          cmd_o.act = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // The final step waits for room in the output register.
        if (status_i.scan_end && !status_i.slot_free) begin
          cmd_o.rd_sel = RD_HOLD;
        end else begin
          cmd_o.rd_sel    = RD_NEXT;
          cmd_o.scan_step = 1'b1;
          if (status_i.scan_end) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/sdc_datapath.sv
// Datapath: signal state, handler table, scan step logic and result register.
`default_nettype none

module sdc_datapath
  import sdc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ctrl_cmd_t cmd_i,
  input  wire item_t     item_i,
  output dp_status_t     status_o,
  sdc_rsp_if.source      rsp_o
);

  // Latched request.
  item_t item_q;

  // Process signal state.
  logic [MaskW-1:0] pending_q, pending_d;
  logic [MaskW-1:0] block_q, block_d;
  logic [MaskW-1:0] saved_q, saved_d;
  logic             in_handler_q, in_handler_d;
  logic             killed_q, killed_d;
  logic [SigW-1:0]  idx_q, idx_d;

  // Handler table: entry valid bits and RAM read side.
  logic [TableDepth-1:0] tbl_valid_q;
  logic                  rd_valid_q;
  logic [SigW-1:0]       raddr;
  logic [EntryW-1:0]     rdata;
  logic                  tbl_we;
  logic [HandW-1:0]      entry_hand;
  logic [MaskW-1:0]      entry_mask;

  // Result register.
  logic             rsp_valid_q, rsp_valid_d;
  logic             r_status_q, r_status_d;
  logic [MaskW-1:0] r_mask_q, r_mask_d;
  logic [HandW-1:0] r_hand_q, r_hand_d;
  logic [SigW-1:0]  r_sig_q, r_sig_d;
  logic             r_started_q, r_started_d;
  logic             r_killed_q, r_killed_d;
  logic             r_stopped_q, r_stopped_d;

  // Decoded request.
  logic [SigW-1:0]  sig;
  logic             sig_ok;
  logic             guard_hit;
  logic             act_reject;
  logic [MaskW-1:0] sig_bit;

  // Scan step terms.
  logic             step_active;
  logic             step_user;
  logic             step_stop;
  logic             step_last;
  logic [MaskW-1:0] scan_pending;
  logic             scan_killed;

  assign sig       = item_q.signal_number[SigW-1:0];
  // NumSignals never exceeds the table depth, so this also rejects numbers above 31.
  assign sig_ok    = {1'b0, item_q.signal_number} < (SigInW + 1)'(NumSignals);
  assign guard_hit = |(item_q.mask_in & GuardMask);
  assign sig_bit   = MaskW'(1) << sig;
  assign act_reject = (sig == SigW'(KillSignal)) || (sig == SigW'(StopSignal)) || guard_hit;

  // An entry never written reads as the default action with an empty mask.
  assign entry_hand = rd_valid_q ? rdata[EntryW-1:MaskW] : HandlerDefault;
  assign entry_mask = rd_valid_q ? rdata[MaskW-1:0] : '0;

  // Table read address.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_SIG:  raddr = sig;
      RD_ZERO: raddr = '0;
      RD_NEXT: raddr = idx_q + SigW'(1);
      RD_HOLD: raddr = idx_q;
      default: raddr = idx_q;
    endcase
  end

  assign tbl_we = cmd_i.act && !act_reject;

  sdc_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (sig),
    .wdata_i ({item_q.handler_address, item_q.mask_in}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // One scan step on signal idx_q, using the entry fetched the cycle before.
  always_comb begin
    scan_pending = pending_q;
    scan_killed  = killed_q;
    step_user    = 1'b0;
    step_stop    = 1'b0;
    step_active  = pending_q[idx_q] && !block_q[idx_q];
    if (step_active) begin
      if (entry_hand == HandlerIgnore) begin
        scan_pending[idx_q] = 1'b0;
      end else if (entry_hand == HandlerDefault) begin
        if (idx_q == SigW'(StopSignal)) begin
          // Stop is cancelled by a pending continue, otherwise it halts the scan.
          if (pending_q[ContSignal]) begin
            scan_pending[StopSignal] = 1'b0;
            scan_pending[ContSignal] = 1'b0;
          end else begin
            step_stop = 1'b1;
          end
        end else if (idx_q == SigW'(ContSignal)) begin
          if (!pending_q[StopSignal]) begin
            scan_pending[idx_q] = 1'b0;
          end
        end else begin
          scan_killed         = 1'b1;
          scan_pending[idx_q] = 1'b0;
        end
      end else begin
        step_user           = 1'b1;
        scan_pending[idx_q] = 1'b0;
      end
    end
    step_last = step_user || step_stop || (idx_q == SigW'(NumSignals - 1));
  end

  // Status to the controller.
  always_comb begin
    status_o.act_read     = (op_e'(item_q.operation) == OP_SET_ACTION) && sig_ok;
    status_o.deliver_scan = (op_e'(item_q.operation) == OP_DELIVER) && !in_handler_q;
    status_o.slot_free    = !rsp_valid_q || rsp_o.ready;
    status_o.scan_end     = step_last;
  end

  // Next state and result.
  always_comb begin
    pending_d    = pending_q;
    block_d      = block_q;
    saved_d      = saved_q;
    in_handler_d = in_handler_q;
    killed_d     = killed_q;
    idx_d        = idx_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    r_status_d   = r_status_q;
    r_mask_d     = r_mask_q;
    r_hand_d     = r_hand_q;
    r_sig_d      = r_sig_q;
    r_started_d  = r_started_q;
    r_killed_d   = r_killed_q;
    r_stopped_d  = r_stopped_q;

    if (cmd_i.exec) begin
      // Operations that finish without a table access.
      r_status_d = 1'b0;
      r_mask_d   = '0;
      unique case (op_e'(item_q.operation))
        OP_SEND: begin
          if (sig_ok) begin
            pending_d = pending_q | sig_bit;
          end else begin
            r_status_d = 1'b1;
          end
        end
        OP_SET_MASK: begin
          if (guard_hit) begin
            r_status_d = 1'b1;
          end else begin
            r_mask_d = block_q;
            block_d  = item_q.mask_in;
          end
        end
        OP_SET_ACTION: begin
          r_status_d = 1'b1;
        end
        OP_DELIVER: begin
          r_status_d = 1'b0;
        end
        OP_RETURN: begin
          block_d      = saved_q;
          in_handler_d = 1'b0;
        end
        default: begin
          r_status_d = 1'b1;
        end
      endcase
      rsp_valid_d = 1'b1;
      r_hand_d    = '0;
      r_sig_d     = '0;
      r_started_d = 1'b0;
      r_killed_d  = killed_q;
      r_stopped_d = 1'b0;
    end

    if (cmd_i.act) begin
      // Set action: the old entry is returned even when the change is refused.
      rsp_valid_d = 1'b1;
      r_status_d  = act_reject;
      r_mask_d    = entry_mask;
      r_hand_d    = entry_hand;
      r_sig_d     = '0;
      r_started_d = 1'b0;
      r_killed_d  = killed_q;
      r_stopped_d = 1'b0;
    end

    if (cmd_i.scan_init) begin
      idx_d = '0;
    end

    if (cmd_i.scan_step) begin
      pending_d = scan_pending;
      killed_d  = scan_killed;
      idx_d     = idx_q + SigW'(1);
      if (step_user) begin
        saved_d      = block_q;
        block_d      = entry_mask;
        in_handler_d = 1'b1;
      end
      if (step_last) begin
        rsp_valid_d = 1'b1;
        r_status_d  = 1'b0;
        r_mask_d    = '0;
        r_hand_d    = step_user ? entry_hand : '0;
        r_sig_d     = step_user ? idx_q : '0;
        r_started_d = step_user;
        r_killed_d  = scan_killed;
        r_stopped_d = step_stop;
      end
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= '0;
      block_q      <= '0;
      saved_q      <= '0;
      in_handler_q <= 1'b0;
      killed_q     <= 1'b0;
      idx_q        <= '0;
      tbl_valid_q  <= '0;
      rd_valid_q   <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      pending_q    <= pending_d;
      block_q      <= block_d;
      saved_q      <= saved_d;
      in_handler_q <= in_handler_d;
      killed_q     <= killed_d;
      idx_q        <= idx_d;
      rd_valid_q   <= tbl_valid_q[raddr];
      rsp_valid_q  <= rsp_valid_d;
      if (tbl_we) begin
        tbl_valid_q[sig] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    r_status_q  <= r_status_d;
    r_mask_q    <= r_mask_d;
    r_hand_q    <= r_hand_d;
    r_sig_q     <= r_sig_d;
    r_started_q <= r_started_d;
    r_killed_q  <= r_killed_d;
    r_stopped_q <= r_stopped_d;
  end

  // Response channel.
  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = r_status_q;
  assign rsp_o.mask_out        = r_mask_q;
  assign rsp_o.handler_out     = r_hand_q;
  assign rsp_o.signal_out      = r_sig_q;
  assign rsp_o.handler_started = r_started_q;
  assign rsp_o.killed_flag     = r_killed_q;
  assign rsp_o.stopped_flag    = r_stopped_q;

endmodule

`default_nettype wire

FILE: rtl/core/signal_delivery_controller_core.sv
// Top level of the signal delivery controller.
//
//   Channel  Direction  Payload
//   req_i    in         operation, signal_number, mask_in, handler_address
//   rsp_o    out        status, mask_out, handler_out, signal_out,
//                       handler_started, killed_flag, stopped_flag
//
// One transaction at a time: send, set mask, handler return and rejected
// operations end in the execute state, set action in the action state (one
// table read). Deliver scans up to NumSignals signals, one per cycle save the
// last step, which waits for output room; each entry is fetched a step ahead.
// Reset clears all signal state and the table's entry valid bits at once.
// A waiting result never blocks the next request; only the result of a
// following transaction waits for the output register to drain.
`default_nettype none

module signal_delivery_controller_core
  import sdc_pkg::*;
(
  input wire logic  clk_i,
  input wire logic  rst_ni,
  sdc_req_if.sink   req_i,
  sdc_rsp_if.source rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  item_t      item;
  logic       in_ready;

  always_comb begin
    item.operation       = req_i.operation;
    item.signal_number   = req_i.signal_number;
    item.mask_in         = req_i.mask_in;
    item.handler_address = req_i.handler_address;
  end

  assign req_i.ready = in_ready;

  sdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sdc_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item),
    .status_o (status),
    .rsp_o    (rsp_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the signal delivery controller core.
`timescale 1ns / 1ps

module testbench
  import sdc_pkg::*;
();

  // Outcome of one transaction, in the order of the response fields.
  typedef struct packed {
    logic             status;
    logic [MaskW-1:0] mask_out;
    logic [HandW-1:0] handler_out;
    logic [SigW-1:0]  signal_out;
    logic             handler_started;
    logic             killed_flag;
    logic             stopped_flag;
  } outcome_t;

  // A queued request; drain_first holds it back until every result is in.
  typedef struct {
    item_t item;
    bit    drain_first;
  } queued_req_t;

  localparam int unsigned RandomReqs = 1500;
  localparam int unsigned TailReqs   = 150;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned MaxPrinted = 100;

  logic clk;
  logic rst_n;

  sdc_req_if req ();
  sdc_rsp_if rsp ();

  signal_delivery_controller_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Predicted process signal state.
  logic [MaskW-1:0] pend_sigs;
  logic [MaskW-1:0] blk_mask;
  logic [MaskW-1:0] sav_mask;
  logic             in_hnd;
  logic             proc_killed;
  logic [HandW-1:0] act_addr [TableDepth];
  logic [MaskW-1:0] act_mask [TableDepth];

  queued_req_t request_queue[$];
  outcome_t    expected_outcomes[$];
  bit          drain_mark;

  // Driver state.
  item_t       cur_item;
  queued_req_t next_req;
  int unsigned sent_cnt;
  int unsigned gap_left;
  logic        tail_q;

  // Monitor state.
  outcome_t    got;
  outcome_t    want;
  int unsigned got_cnt;
  int unsigned n_got;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned n_err;
  int unsigned cycle_cnt;

  always #2 clk = ~clk;

  function automatic bit sig_ok(logic [SigInW-1:0] s);
    return s <= 31 && s < NumSignals;
  endfunction

  // Applies one request to the predicted state and returns its outcome.
  function automatic outcome_t predict_signal_op(item_t it);
    outcome_t         r;
    logic [SigW-1:0]  s;
    logic [HandW-1:0] h;
    bit               done;
    r = '0;
    s = it.signal_number[SigW-1:0];
    case (it.operation)
      OP_SEND: begin
        if (sig_ok(it.signal_number)) pend_sigs[s] = 1'b1;
        else r.status = 1'b1;
      end
      OP_SET_MASK: begin
        if (|(it.mask_in & GuardMask)) begin
          r.status = 1'b1;
        end else begin
          r.mask_out = blk_mask;
          blk_mask = it.mask_in;
        end
      end
      OP_SET_ACTION: begin
        if (!sig_ok(it.signal_number)) begin
          r.status = 1'b1;
        end else begin
          r.mask_out = act_mask[s];
          r.handler_out = act_addr[s];
          if (s == KillSignal || s == StopSignal || |(it.mask_in & GuardMask)) begin
            r.status = 1'b1;
          end else begin
            act_addr[s] = it.handler_address;
            act_mask[s] = it.mask_in;
          end
        end
      end
      OP_DELIVER: begin
        done = 1'b0;
        // Ascending scan over pending, unblocked signals.
        for (int i = 0; i < NumSignals && !in_hnd && !done; i++) begin
          if (pend_sigs[i] && !blk_mask[i]) begin
            h = act_addr[i];
            if (h == HandlerIgnore) begin
              pend_sigs[i] = 1'b0;
            end else if (h == HandlerDefault) begin
              if (i == StopSignal) begin
                if (pend_sigs[ContSignal]) begin
                  pend_sigs[i] = 1'b0;
                  pend_sigs[ContSignal] = 1'b0;
                end else begin
                  r.stopped_flag = 1'b1;
                  done = 1'b1;
                end
              end else if (i == ContSignal) begin
                if (!pend_sigs[StopSignal]) pend_sigs[i] = 1'b0;
              end else begin
                proc_killed = 1'b1;
                pend_sigs[i] = 1'b0;
              end
            end else begin
              // A user handler swaps the masks and ends the scan.
              sav_mask = blk_mask;
              blk_mask = act_mask[i];
              in_hnd = 1'b1;
              pend_sigs[i] = 1'b0;
              r.handler_out = h;
              r.signal_out = i[SigW-1:0];
              r.handler_started = 1'b1;
              done = 1'b1;
            end
          end
        end
      end
      OP_RETURN: begin
        blk_mask = sav_mask;
        in_hnd = 1'b0;
      end
      default: begin
        r.status = 1'b1;
      end
    endcase
    r.killed_flag = proc_killed;
    return r;
  endfunction

  task automatic add_req(logic [OpW-1:0] op, logic [SigInW-1:0] sig,
                         logic [MaskW-1:0] msk, logic [HandW-1:0] addr);
    queued_req_t q;
    q.item.operation = op;
    q.item.signal_number = sig;
    q.item.mask_in = msk;
    q.item.handler_address = addr;
    q.drain_first = drain_mark;
    drain_mark = 1'b0;
    request_queue.push_back(q);
  endtask

  function automatic logic [HandW-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // Random mask, mostly without the kill and stop bits.
  function automatic logic [MaskW-1:0] rand_mask();
    logic [MaskW-1:0] m;
    m = $urandom;
    if ($urandom_range(0, 7) != 0) m = m & ~GuardMask;
    return m;
  endfunction

  // Random handler: default, ignore or a user address.
  function automatic logic [HandW-1:0] rand_handler();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 2) return HandlerDefault;
    if (k < 4) return HandlerIgnore;
    return rand_addr();
  endfunction

  function automatic logic [SigInW-1:0] rand_sig();
    logic [SigInW-1:0] s;
    s = SigInW'($urandom_range(0, NumSignals - 1));
    // Keep kills rare so that most deliveries run real handlers.
    if (s == KillSignal && $urandom_range(0, 7) != 0) s = s + SigInW'(1);
    return s;
  endfunction

  task automatic report_mismatch(string what);
    if (n_err < MaxPrinted) $display("mismatch at result %0d: %s", got_cnt, what);
    n_err++;
  endtask

  task automatic check_field(string name, logic [HandW-1:0] g, logic [HandW-1:0] w);
    if (g !== w) report_mismatch($sformatf("%s is %0h, expected %0h", name, g, w));
  endtask

  // Request driver.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req.valid <= 1'b0;
      req.operation <= '0;
      req.signal_number <= '0;
      req.mask_in <= '0;
      req.handler_address <= '0;
      gap_left = 0;
      sent_cnt = 0;
      tail_q <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        expected_outcomes.push_back(predict_signal_op(cur_item));
        sent_cnt++;
      end
      tail_q <= request_queue.size() < TailReqs;
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (request_queue.size() == 0 ||
                     (request_queue[0].drain_first && sent_cnt != n_got)) begin
          req.valid <= 1'b0;
        end else if (!tail_q && (sent_cnt % 300) >= 60 && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(1, 19) - 1;
          req.valid <= 1'b0;
        end else begin
          next_req = request_queue.pop_front();
          cur_item = next_req.item;
          req.valid <= 1'b1;
          req.operation <= cur_item.operation;
          req.signal_number <= cur_item.signal_number;
          req.mask_in <= cur_item.mask_in;
          req.handler_address <= cur_item.handler_address;
        end
      end
    end
  end

  // Response monitor and checker.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp.ready <= 1'b0;
      got_cnt = 0;
      n_got <= 0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.mask_out = rsp.mask_out;
        got.handler_out = rsp.handler_out;
        got.signal_out = rsp.signal_out;
        got.handler_started = rsp.handler_started;
        got.killed_flag = rsp.killed_flag;
        got.stopped_flag = rsp.stopped_flag;
        if (expected_outcomes.size() == 0) begin
          report_mismatch("transaction with no expected result");
        end else begin
          want = expected_outcomes.pop_front();
          check_field("status", HandW'(got.status), HandW'(want.status));
          check_field("mask_out", HandW'(got.mask_out), HandW'(want.mask_out));
          check_field("handler_out", got.handler_out, want.handler_out);
          check_field("signal_out", HandW'(got.signal_out), HandW'(want.signal_out));
          check_field("handler_started", HandW'(got.handler_started),
                      HandW'(want.handler_started));
          check_field("killed_flag", HandW'(got.killed_flag), HandW'(want.killed_flag));
          check_field("stopped_flag", HandW'(got.stopped_flag),
                      HandW'(want.stopped_flag));
        end
        got_cnt++;
        n_got <= got_cnt;
        // Long hold-off so that the core backs up and stalls its input.
        if (got_cnt == 300 || got_cnt == 1000) hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (!tail_q && (got_cnt % 300) >= 60 && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned k;
    logic [SigInW-1:0] s;
    clk = 1'b0;
    rst_n = 1'b0;
    n_err = 0;
    cycle_cnt = 0;
    drain_mark = 1'b0;
    pend_sigs = '0;
    blk_mask = '0;
    sav_mask = '0;
    in_hnd = 1'b0;
    proc_killed = 1'b0;
    for (int i = 0; i < TableDepth; i++) begin
      act_addr[i] = HandlerDefault;
      act_mask[i] = '0;
    end

    // Directed: table extremes and rejected actions.
    add_req(OP_SET_ACTION, 6'd5, '0, '1);
    add_req(OP_SET_ACTION, 6'd5, ~GuardMask, 64'h1000);
    add_req(OP_SET_ACTION, SigInW'(KillSignal), '0, 64'h2000);
    add_req(OP_SET_ACTION, SigInW'(StopSignal), '0, 64'h2000);
    add_req(OP_SET_ACTION, 6'd5, GuardMask, 64'h3000);
    add_req(OP_SET_ACTION, '1, '0, 64'h4000);
    add_req(OP_SET_ACTION, SigInW'(NumSignals), '0, 64'h4000);
    add_req(OP_SEND, '1, '0, '0);
    add_req(OP_SET_MASK, '0, MaskW'(1) << StopSignal, '0);
    add_req(OP_SET_MASK, '0, ~GuardMask, '0);
    add_req(OP_SET_MASK, '0, '0, '0);
    // Ignored signal, then a user handler, a nested deliver and the return.
    add_req(OP_SET_ACTION, 6'd0, '0, HandlerIgnore);
    add_req(OP_SEND, 6'd0, '0, '0);
    add_req(OP_SEND, 6'd5, '0, '0);
    add_req(OP_DELIVER, '0, '0, '0);
    add_req(OP_DELIVER, '0, '0, '0);
    add_req(OP_RETURN, '0, '0, '0);
    add_req(OP_RETURN, '0, '0, '0);
    // Stop waits for continue; continue alone is dropped.
    add_req(OP_SEND, SigInW'(StopSignal), '0, '0);
    add_req(OP_DELIVER, '0, '0, '0);
    add_req(OP_SEND, SigInW'(ContSignal), '0, '0);
    add_req(OP_DELIVER, '0, '0, '0);
    add_req(OP_SEND, SigInW'(ContSignal), '0, '0);
    add_req(OP_DELIVER, '0, '0, '0);
    for (int op = OP_RETURN + 1; op < 2 ** OpW; op++) add_req(OpW'(op), '1, '1, '1);
    // A default action on an ordinary signal kills the process.
    add_req(OP_SEND, SigInW'(KillSignal), '0, '0);
    add_req(OP_DELIVER, '0, '0, '0);

    // Random: mostly send and deliver episodes, with table and mask churn.
    k = request_queue.size();
    while (request_queue.size() < k + RandomReqs) begin
      if (request_queue.size() >= k + 600 && request_queue.size() < k + 603) drain_mark = 1'b1;
      if (request_queue.size() >= k + 1200 && request_queue.size() < k + 1203) drain_mark = 1'b1;
      case ($urandom_range(0, 99)) inside
        [0:44]: begin
          repeat ($urandom_range(1, 3)) add_req(OP_SEND, rand_sig(), $urandom, rand_addr());
          add_req(OP_DELIVER, SigInW'($urandom), $urandom, rand_addr());
          if ($urandom_range(0, 4) == 0) begin
            add_req(OP_DELIVER, SigInW'($urandom), $urandom, rand_addr());
          end
          if ($urandom_range(0, 4) != 0) begin
            add_req(OP_RETURN, SigInW'($urandom), $urandom, rand_addr());
          end
        end
        [45:64]: begin
          s = SigInW'($urandom_range(0, NumSignals - 1));
          add_req(OP_SET_ACTION, s, rand_mask(), rand_handler());
        end
        [65:74]: begin
          add_req(OP_SET_MASK, SigInW'($urandom), rand_mask(), rand_addr());
        end
        [75:79]: begin
          add_req(OP_RETURN, SigInW'($urandom), $urandom, rand_addr());
        end
        default: begin
          add_req(OpW'($urandom_range(0, 2 ** OpW - 1)),
                  SigInW'($urandom_range(0, 2 ** SigInW - 1)), $urandom, rand_addr());
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() != 0 || req.valid) @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (4 * NumSignals) @(posedge clk);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sdc_pkg.sv
rtl/core/sdc_if.sv
rtl/core/sdc_ram.sv
rtl/core/sdc_ctrl.sv
rtl/core/sdc_datapath.sv
rtl/core/signal_delivery_controller_core.sv
tb/sv/testbench.sv
